@@ rtl/core/four_char_word_vm_executor_macros.svh @@
// Assertion macros shared by the checker of the word machine executor.
// Depends on nothing; the using module must declare clk and rst_n.
// Guarded so that more than one include is harmless.
`ifndef FOUR_CHAR_WORD_VM_EXECUTOR_MACROS_SVH
`define FOUR_CHAR_WORD_VM_EXECUTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VMX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/vmx_pkg.sv @@
// Shared types, constants and helper functions of the word machine executor.
// Depends on nothing; every other file but the assertion macro header imports it.
package vmx_pkg;

  localparam int MEM_WORDS   = 100;
  localparam int BLOCK_WORDS = 10;
  localparam int DATA_CHARS  = BLOCK_WORDS * 4;

  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int CNT_W  = $clog2(MEM_WORDS + 1);
  localparam int DPOS_W = $clog2(DATA_CHARS + 1);
  localparam int BCNT_W = $clog2(BLOCK_WORDS + 1);
  localparam int OPND_W = 7;
  localparam int OP_W   = 3;
  localparam int KIND_W = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_PCHAR = 3'd1;
  localparam logic [OP_W-1:0] OP_LEND  = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP  = 3'd3;
  localparam logic [OP_W-1:0] OP_DCHAR = 3'd4;
  localparam logic [OP_W-1:0] OP_DEND  = 3'd5;

  localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HALT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] SPACES = {4{CH_SPACE}};
  localparam logic [31:0] H_WORD = {CH_H, CH_SPACE, CH_SPACE, CH_SPACE};

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_LOAD,
    MODE_RUN,
    MODE_WAIT
  } mode_t;

  typedef enum logic [2:0] {
    INS_GD,
    INS_PD,
    INS_H,
    INS_LR,
    INS_SR,
    INS_CR,
    INS_BT,
    INS_OTHER
  } ins_t;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_CLEAR,
    UOP_LINE_END,
    UOP_RD_LOAD,
    UOP_WR_LOAD_CHAR,
    UOP_WR_LOAD_PAD,
    UOP_WR_LOAD_H,
    UOP_START_RUN,
    UOP_RD_IR,
    UOP_LATCH_IR,
    UOP_IC_INC,
    UOP_IC_JUMP,
    UOP_GD,
    UOP_PD_START,
    UOP_RD_PD,
    UOP_OUT_PD,
    UOP_FAIL,
    UOP_HALT,
    UOP_RD_OPND,
    UOP_LR,
    UOP_SR,
    UOP_CR,
    UOP_RD_DATA,
    UOP_WR_DATA_CHAR,
    UOP_WR_DATA_PAD,
    UOP_DATA_DONE
  } uop_t;

  typedef struct packed {
    logic accept;
    uop_t uop;
  } vmx_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    mode_t           mode;
    logic            ch_is_h;
    logic            load_pos_zero;
    logic            load_full;
    logic            ic_oob;
    ins_t            ins;
    logic            opnd_ok;
    logic            addr_ok;
    logic            blk_ok;
    logic            c_flag;
    logic            data_full;
    logic            pd_last;
    logic            out_busy;
  } vmx_status_t;

  // Replaces the character at position pos (0 is the top byte).
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                           input logic [7:0] c);
    logic [31:0] r;
    r = w;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) == pos) begin
        r[8*(3-i) +: 8] = c;
      end
    end
    return r;
  endfunction

  // Fills every character from position pos to the end of the word with spaces.
  function automatic logic [31:0] pad_from(input logic [31:0] w, input logic [1:0] pos);
    logic [31:0] r;
    r = w;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) >= pos) begin
        r[8*(3-i) +: 8] = CH_SPACE;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/vmx_in_if.sv @@
// Input channel of the word machine executor: valid, ready and one item.
// Depends on vmx_pkg for the field widths.
interface vmx_in_if import vmx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [7:0]      ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

@@ rtl/core/vmx_out_if.sv @@
// Result channel of the word machine executor: valid, ready and one item.
// Depends on vmx_pkg for the field widths.
interface vmx_out_if import vmx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [31:0]       out_word;
  logic              last;

  modport source (output valid, output out_kind, output out_word, output last, input ready);
  modport sink   (input valid, input out_kind, input out_word, input last, output ready);
endinterface

@@ rtl/core/vmx_dpath.sv @@
// Datapath of the word machine executor: word memory, machine registers,
// instruction decode and the result register. Depends on vmx_pkg.
module vmx_dpath import vmx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  vmx_cmd_t          cmd,
  input  logic [OP_W-1:0]   in_op,
  input  logic [7:0]        in_ch,
  output vmx_status_t       status,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic [31:0]       out_word,
  output logic              out_last
);

  logic [31:0]       mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_r;
  logic [31:0]       mem_q_r;
  logic              vld_q_r;
  logic [31:0]       rd_word;

  logic [OP_W-1:0]   op_r;
  logic [7:0]        ch_r;
  logic [31:0]       ir_r;
  mode_t             mode_r;
  logic [CNT_W-1:0]  ic_r;
  logic [31:0]       greg_r;
  logic              cflag_r;
  logic [CNT_W-1:0]  load_addr_r;
  logic [1:0]        load_pos_r;
  logic [OPND_W-1:0] data_addr_r;
  logic [DPOS_W-1:0] data_pos_r;
  logic [ADDR_W-1:0] pd_addr_r;
  logic [BCNT_W-1:0] pd_cnt_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [31:0]       out_word_r;
  logic              out_last_r;

  logic [7:0]        ir_a;
  logic [7:0]        ir_b;
  logic [7:0]        ir_hi;
  logic [7:0]        ir_lo;
  logic              digits_ok;
  logic [OPND_W-1:0] opnd;
  ins_t              ins;

  logic [OPND_W:0]   data_w;
  logic              data_w_ok;
  logic [DPOS_W-3:0] data_word_nxt;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic              out_load;

  assign rd_word = vld_q_r ? mem_q_r : SPACES;

  // Instruction decode, in the order of priority of the opcodes.
  assign ir_a  = ir_r[31:24];
  assign ir_b  = ir_r[23:16];
  assign ir_hi = ir_r[15:8];
  assign ir_lo = ir_r[7:0];
  assign digits_ok = (ir_hi >= CH_ZERO) && (ir_hi <= CH_NINE) &&
                     (ir_lo >= CH_ZERO) && (ir_lo <= CH_NINE);
  assign opnd = OPND_W'({3'b000, ir_hi[3:0]} * 7'd10) + OPND_W'(ir_lo[3:0]);

  always_comb begin
    priority if (ir_a == CH_G && ir_b == CH_D) begin
      ins = INS_GD;
    end else if (ir_a == CH_P && ir_b == CH_D) begin
      ins = INS_PD;
    end else if (ir_a == CH_H) begin
      ins = INS_H;
    end else if (ir_a == CH_L && ir_b == CH_R) begin
      ins = INS_LR;
    end else if (ir_a == CH_S && ir_b == CH_R) begin
      ins = INS_SR;
    end else if (ir_a == CH_C && ir_b == CH_R) begin
      ins = INS_CR;
    end else if (ir_a == CH_B && ir_b == CH_T) begin
      ins = INS_BT;
    end else begin
      ins = INS_OTHER;
    end
  end

  assign data_w = (OPND_W+1)'(data_addr_r) + (OPND_W+1)'(data_pos_r[DPOS_W-1:2]);
  assign data_w_ok = int'(data_w) < MEM_WORDS;
  assign data_word_nxt = data_pos_r[DPOS_W-1:2] + (DPOS_W-2)'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = SPACES;
    unique case (cmd.uop)
      UOP_RD_LOAD: begin
        rd_en   = 1'b1;
        rd_addr = load_addr_r[ADDR_W-1:0];
      end
      UOP_WR_LOAD_CHAR: begin
        wr_en   = 1'b1;
        wr_addr = load_addr_r[ADDR_W-1:0];
        wr_data = put_byte(rd_word, load_pos_r, ch_r);
      end
      UOP_WR_LOAD_PAD: begin
        wr_en   = 1'b1;
        wr_addr = load_addr_r[ADDR_W-1:0];
        wr_data = pad_from(rd_word, load_pos_r);
      end
      UOP_WR_LOAD_H: begin
        wr_en   = 1'b1;
        wr_addr = load_addr_r[ADDR_W-1:0];
        wr_data = H_WORD;
      end
      UOP_RD_IR: begin
        rd_en   = 1'b1;
        rd_addr = ic_r[ADDR_W-1:0];
      end
      UOP_RD_PD: begin
        rd_en   = 1'b1;
        rd_addr = pd_addr_r;
      end
      UOP_RD_OPND: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(opnd);
      end
      UOP_SR: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(opnd);
        wr_data = greg_r;
      end
      UOP_RD_DATA: begin
        rd_en   = data_w_ok;
        rd_addr = ADDR_W'(data_w);
      end
      UOP_WR_DATA_CHAR: begin
        wr_en   = data_w_ok;
        wr_addr = ADDR_W'(data_w);
        wr_data = put_byte(rd_word, data_pos_r[1:0], ch_r);
      end
      UOP_WR_DATA_PAD: begin
        wr_en   = data_w_ok;
        wr_addr = ADDR_W'(data_w);
        wr_data = pad_from(rd_word, data_pos_r[1:0]);
      end
      default: begin
      end
    endcase
  end

  assign out_load = (cmd.uop == UOP_OUT_PD) || (cmd.uop == UOP_FAIL) ||
                    (cmd.uop == UOP_HALT) || (cmd.uop == UOP_GD);

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      vld_q_r <= vld_r[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_op;
      ch_r <= in_ch;
    end
    if (cmd.uop == UOP_LATCH_IR) begin
      ir_r <= rd_word;
    end
    if (cmd.uop == UOP_PD_START) begin
      pd_addr_r <= ADDR_W'(opnd);
      pd_cnt_r  <= '0;
    end else if (cmd.uop == UOP_OUT_PD) begin
      pd_addr_r <= pd_addr_r + ADDR_W'(1);
      pd_cnt_r  <= pd_cnt_r + BCNT_W'(1);
    end
    if (out_load) begin
      unique case (cmd.uop)
        UOP_OUT_PD: begin
          out_kind_r <= KIND_WORD;
          out_word_r <= rd_word;
          out_last_r <= int'(pd_cnt_r) == BLOCK_WORDS - 1;
        end
        UOP_FAIL: begin
          out_kind_r <= KIND_ERROR;
          out_word_r <= '0;
          out_last_r <= 1'b1;
        end
        UOP_HALT: begin
          out_kind_r <= KIND_HALT;
          out_word_r <= '0;
          out_last_r <= 1'b1;
        end
        default: begin
          out_kind_r <= KIND_NEED;
          out_word_r <= '0;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  // Machine state and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      mode_r      <= MODE_IDLE;
      ic_r        <= '0;
      greg_r      <= SPACES;
      cflag_r     <= 1'b0;
      load_addr_r <= '0;
      load_pos_r  <= '0;
      data_addr_r <= '0;
      data_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.uop == UOP_CLEAR) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.uop)
        UOP_CLEAR: begin
          mode_r      <= MODE_LOAD;
          ic_r        <= '0;
          greg_r      <= SPACES;
          cflag_r     <= 1'b0;
          load_addr_r <= '0;
          load_pos_r  <= '0;
          data_addr_r <= '0;
          data_pos_r  <= '0;
        end
        UOP_LINE_END: begin
          load_pos_r <= '0;
        end
        UOP_WR_LOAD_CHAR: begin
          load_pos_r <= load_pos_r + 2'd1;
          if (load_pos_r == 2'd3) begin
            load_addr_r <= load_addr_r + CNT_W'(1);
          end
        end
        UOP_WR_LOAD_PAD: begin
          load_pos_r  <= '0;
          load_addr_r <= load_addr_r + CNT_W'(1);
        end
        UOP_WR_LOAD_H: begin
          load_addr_r <= load_addr_r + CNT_W'(1);
        end
        UOP_START_RUN: begin
          ic_r   <= '0;
          mode_r <= MODE_RUN;
        end
        UOP_IC_INC, UOP_PD_START, UOP_SR: begin
          ic_r <= ic_r + CNT_W'(1);
        end
        UOP_IC_JUMP: begin
          ic_r <= CNT_W'(opnd);
        end
        UOP_GD: begin
          ic_r        <= ic_r + CNT_W'(1);
          data_addr_r <= opnd;
          data_pos_r  <= '0;
          mode_r      <= MODE_WAIT;
        end
        UOP_FAIL, UOP_HALT: begin
          mode_r <= MODE_IDLE;
        end
        UOP_LR: begin
          greg_r <= rd_word;
          ic_r   <= ic_r + CNT_W'(1);
        end
        UOP_CR: begin
          cflag_r <= greg_r == rd_word;
          ic_r    <= ic_r + CNT_W'(1);
        end
        UOP_WR_DATA_CHAR: begin
          data_pos_r <= data_pos_r + DPOS_W'(1);
        end
        UOP_WR_DATA_PAD: begin
          data_pos_r <= {data_word_nxt, 2'b00};
        end
        UOP_DATA_DONE: begin
          mode_r <= MODE_RUN;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.op            = op_r;
  assign status.mode          = mode_r;
  assign status.ch_is_h       = ch_r == CH_H;
  assign status.load_pos_zero = load_pos_r == 2'd0;
  assign status.load_full     = int'(load_addr_r) >= MEM_WORDS;
  assign status.ic_oob        = int'(ic_r) >= MEM_WORDS;
  assign status.ins           = ins;
  assign status.opnd_ok       = digits_ok;
  assign status.addr_ok       = int'(opnd) < MEM_WORDS;
  assign status.blk_ok        = int'(opnd) + BLOCK_WORDS <= MEM_WORDS;
  assign status.c_flag        = cflag_r;
  assign status.data_full     = int'(data_pos_r) >= DATA_CHARS;
  assign status.pd_last       = int'(pd_cnt_r) == BLOCK_WORDS - 1;
  assign status.out_busy      = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/core/vmx_ctrl.sv @@
// Sequencer of the word machine executor: takes items and issues one
// micro-operation per cycle to the datapath. Depends on vmx_pkg.
module vmx_ctrl import vmx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  vmx_status_t status,
  output vmx_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_LD_WR,
    S_LDH_PAD,
    S_LDH_CHK,
    S_FAIL,
    S_IR_CHK,
    S_IR_LATCH,
    S_EXEC,
    S_NEED,
    S_HALT,
    S_OP_DO,
    S_PD_RD,
    S_PD_OUT,
    S_DC_WR,
    S_DE_CHK,
    S_DE_WR
  } state_t;

  state_t state_r;
  state_t state_nxt;
  uop_t   uop;
  logic   bad_addr;
  logic   bad_blk;

  assign bad_addr = !status.opnd_ok || !status.addr_ok;
  assign bad_blk  = !status.opnd_ok || !status.blk_ok;

  always_comb begin
    state_nxt = state_r;
    uop       = UOP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        unique case (status.op)
          OP_CLEAR: begin
            uop = UOP_CLEAR;
          end
          OP_PCHAR: begin
            if (status.mode == MODE_LOAD) begin
              if (status.ch_is_h) begin
                if (status.load_pos_zero) begin
                  state_nxt = S_LDH_CHK;
                end else begin
                  uop       = UOP_RD_LOAD;
                  state_nxt = S_LDH_PAD;
                end
              end else if (status.load_full) begin
                state_nxt = S_FAIL;
              end else begin
                uop       = UOP_RD_LOAD;
                state_nxt = S_LD_WR;
              end
            end
          end
          OP_LEND: begin
            if (status.mode == MODE_LOAD) begin
              uop = UOP_LINE_END;
            end
          end
          OP_STEP: begin
            if (status.mode == MODE_LOAD) begin
              uop       = UOP_START_RUN;
              state_nxt = S_IR_CHK;
            end else if (status.mode == MODE_RUN) begin
              state_nxt = S_IR_CHK;
            end
          end
          OP_DCHAR: begin
            if (status.mode == MODE_WAIT && !status.data_full) begin
              uop       = UOP_RD_DATA;
              state_nxt = S_DC_WR;
            end
          end
          OP_DEND: begin
            if (status.mode == MODE_WAIT) begin
              state_nxt = S_DE_CHK;
            end
          end
          default: begin
          end
        endcase
      end
      S_LD_WR: begin
        uop       = UOP_WR_LOAD_CHAR;
        state_nxt = S_IDLE;
      end
      S_LDH_PAD: begin
        uop       = UOP_WR_LOAD_PAD;
        state_nxt = S_LDH_CHK;
      end
      S_LDH_CHK: begin
        if (status.load_full) begin
          state_nxt = S_FAIL;
        end else begin
          uop       = UOP_WR_LOAD_H;
          state_nxt = S_IDLE;
        end
      end
      S_FAIL: begin
        if (!status.out_busy) begin
          uop       = UOP_FAIL;
          state_nxt = S_IDLE;
        end
      end
      S_IR_CHK: begin
        if (status.ic_oob) begin
          state_nxt = S_FAIL;
        end else begin
          uop       = UOP_RD_IR;
          state_nxt = S_IR_LATCH;
        end
      end
      S_IR_LATCH: begin
        uop       = UOP_LATCH_IR;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (status.ins)
          INS_GD: begin
            state_nxt = bad_blk ? S_FAIL : S_NEED;
          end
          INS_PD: begin
            if (bad_blk) begin
              state_nxt = S_FAIL;
            end else begin
              uop       = UOP_PD_START;
              state_nxt = S_PD_RD;
            end
          end
          INS_H: begin
            state_nxt = S_HALT;
          end
          INS_LR, INS_CR: begin
            if (bad_addr) begin
              state_nxt = S_FAIL;
            end else begin
              uop       = UOP_RD_OPND;
              state_nxt = S_OP_DO;
            end
          end
          INS_SR: begin
            if (bad_addr) begin
              state_nxt = S_FAIL;
            end else begin
              uop = UOP_SR;
            end
          end
          INS_BT: begin
            if (!status.c_flag) begin
              uop = UOP_IC_INC;
            end else if (bad_addr) begin
              state_nxt = S_FAIL;
            end else begin
              uop = UOP_IC_JUMP;
            end
          end
          default: begin
            uop = UOP_IC_INC;
          end
        endcase
      end
      S_NEED: begin
        if (!status.out_busy) begin
          uop       = UOP_GD;
          state_nxt = S_IDLE;
        end
      end
      S_HALT: begin
        if (!status.out_busy) begin
          uop       = UOP_HALT;
          state_nxt = S_IDLE;
        end
      end
      S_OP_DO: begin
        uop       = (status.ins == INS_LR) ? UOP_LR : UOP_CR;
        state_nxt = S_IDLE;
      end
      S_PD_RD: begin
        uop       = UOP_RD_PD;
        state_nxt = S_PD_OUT;
      end
      S_PD_OUT: begin
        if (!status.out_busy) begin
          uop       = UOP_OUT_PD;
          state_nxt = status.pd_last ? S_IDLE : S_PD_RD;
        end
      end
      S_DC_WR: begin
        uop       = UOP_WR_DATA_CHAR;
        state_nxt = S_IDLE;
      end
      S_DE_CHK: begin
        if (status.data_full) begin
          uop       = UOP_DATA_DONE;
          state_nxt = S_IDLE;
        end else begin
          uop       = UOP_RD_DATA;
          state_nxt = S_DE_WR;
        end
      end
      S_DE_WR: begin
        uop       = UOP_WR_DATA_PAD;
        state_nxt = S_DE_CHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready   = state_r == S_IDLE;
  assign cmd.accept = in_valid && (state_r == S_IDLE);
  assign cmd.uop    = uop;

endmodule

@@ rtl/core/four_char_word_vm_executor.sv @@
// Top level of the four-character word machine executor.
// Depends on vmx_pkg, the two channel interfaces, vmx_ctrl and vmx_dpath.
// Usage: items arrive on in_chan (op, ch) and are taken when valid and ready
// are both high. Results leave on out_chan (out_kind, out_word, last) under
// the same handshake. The block works on one item at a time; ready is high
// whenever the sequencer is waiting for work, even if a result is still held
// in the output register, so a stalled receiver only holds back items that
// must themselves produce a result.
// Every partial word update is a read of the word followed by a write, because
// the read of the word memory is registered.
// Reset (rst_n low at a clock edge) empties the result register, sets the
// machine idle and marks every word as four spaces through per-word valid
// flags, so no clearing pass is needed; a job start clears those flags as well.
// If the receiver stalls, the sequencer waits with the next result until the
// output register has been taken.
module four_char_word_vm_executor import vmx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  vmx_in_if.sink     in_chan,
  vmx_out_if.source  out_chan
);

  vmx_cmd_t    cmd;
  vmx_status_t status;

  // The sequencer decides what happens in each cycle; the datapath holds
  // all machine state and only executes the micro-operation it is given.
  vmx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  vmx_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_op     (in_chan.op),
    .in_ch     (in_chan.ch),
    .status    (status),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_kind  (out_chan.out_kind),
    .out_word  (out_chan.out_word),
    .out_last  (out_chan.last)
  );

endmodule

@@ rtl/core/vmx_checker.sv @@
// Port-level checks of the word machine executor, bound to the top level.
// Depends on vmx_pkg and the assertion macro header.
`include "four_char_word_vm_executor_macros.svh"

module vmx_checker import vmx_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [31:0]       out_word,
  input logic              out_last
);

  // A stalled result keeps its contents.
  `VMX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(out_kind) && $stable(out_last), "result changed while stalled")

  // Status results carry no word and always end their group.
  `VMX_ASSERT_SAME(a_status_shape, out_valid && out_kind != KIND_WORD, out_word == 32'd0 && out_last, "status result malformed")

  // While a printed line is unfinished, no new item is taken.
  `VMX_ASSERT_SAME(a_line_busy, out_valid && out_kind == KIND_WORD && !out_last, !in_ready, "item taken during a printed line")

  // A status result is the only result of its item, so none follows at once.
  `VMX_ASSERT_NEXT(a_status_alone, out_valid && out_ready && out_kind != KIND_WORD, !out_valid, "result directly after a status result")

endmodule

bind four_char_word_vm_executor vmx_checker u_vmx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.out_kind),
  .out_word  (out_chan.out_word),
  .out_last  (out_chan.last)
);

@@ tb/vm_job_tracker_pkg.sv @@
// Result tracker for the four-character word machine testbench: a predictor of the machine
// and a queue of the results it still owes. Depends on vmx_pkg for widths, codes and modes.
`timescale 1ns / 1ps
package vm_job_tracker_pkg;
  import vmx_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [31:0]       word;
    logic              last;
  } vm_result_t;

  class vm_job_tracker;
    logic [31:0] mem [MEM_WORDS];
    logic [31:0] r_reg;
    logic        c_flag;
    int unsigned ic;
    int unsigned load_addr;
    int unsigned load_pos;
    int unsigned data_addr;
    int unsigned data_pos;
    mode_t       mode;
    vm_result_t  due_results[$];
    int unsigned mismatches;

    function new();
      clear_machine();
      mode       = MODE_IDLE;
      mismatches = 0;
    endfunction

    function void clear_machine();
      foreach (mem[i]) mem[i] = SPACES;
      r_reg     = SPACES;
      c_flag    = 1'b0;
      ic        = 0;
      load_addr = 0;
      load_pos  = 0;
      data_addr = 0;
      data_pos  = 0;
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [31:0] word, logic last);
      vm_result_t r;
      r.kind = kind;
      r.word = word;
      r.last = last;
      due_results.push_back(r);
    endfunction

    function void fail_job();
      mode = MODE_IDLE;
      push(KIND_ERROR, 32'h0, 1'b1);
    endfunction

    // Address held in the two low characters, or -1 unless both are digits.
    function int operand_of(logic [31:0] w);
      if (w[15:8] < CH_ZERO || w[15:8] > CH_NINE || w[7:0] < CH_ZERO || w[7:0] > CH_NINE)
        return -1;
      return int'(w[15:8] - CH_ZERO) * 10 + int'(w[7:0] - CH_ZERO);
    endfunction

    function void store_char(logic [7:0] ch);
      if (ch == CH_H) begin
        if (load_pos != 0) begin
          for (int p = load_pos; p < 4; p++) mem[load_addr][8*(3-p) +: 8] = CH_SPACE;
          load_addr++;
          load_pos = 0;
        end
        if (load_addr >= MEM_WORDS) begin
          fail_job();
          return;
        end
        mem[load_addr] = H_WORD;
        load_addr++;
        return;
      end
      if (load_addr >= MEM_WORDS) begin
        fail_job();
        return;
      end
      mem[load_addr][8*(3-load_pos) +: 8] = ch;
      load_pos++;
      if (load_pos == 4) begin
        load_pos = 0;
        load_addr++;
      end
    endfunction

    function void run_instruction();
      logic [31:0] ir;
      logic [7:0]  a;
      logic [7:0]  b;
      int          m;
      if (ic >= MEM_WORDS) begin
        fail_job();
        return;
      end
      ir = mem[ic];
      a  = ir[31:24];
      b  = ir[23:16];
      m  = operand_of(ir);
      if ((a == CH_G || a == CH_P) && b == CH_D) begin
        if (m < 0 || m + BLOCK_WORDS > MEM_WORDS) begin
          fail_job();
          return;
        end
        ic++;
        if (a == CH_G) begin
          data_addr = m;
          data_pos  = 0;
          mode      = MODE_WAIT;
          push(KIND_NEED, 32'h0, 1'b1);
        end else begin
          for (int i = 0; i < BLOCK_WORDS; i++)
            push(KIND_WORD, mem[m + i], i == BLOCK_WORDS - 1);
        end
      end else if (a == CH_H) begin
        mode = MODE_IDLE;
        push(KIND_HALT, 32'h0, 1'b1);
      end else if ((a == CH_L || a == CH_S || a == CH_C) && b == CH_R) begin
        if (m < 0 || m >= MEM_WORDS) begin
          fail_job();
          return;
        end
        if (a == CH_L) r_reg = mem[m];
        else if (a == CH_S) mem[m] = r_reg;
        else c_flag = (r_reg == mem[m]);
        ic++;
      end else if (a == CH_B && b == CH_T && c_flag) begin
        if (m < 0 || m >= MEM_WORDS) begin
          fail_job();
          return;
        end
        ic = m;
      end else begin
        ic++;
      end
    endfunction

    // Applies one accepted input item; returns 1 unless the machine ignores it.
    function bit note_input(logic [OP_W-1:0] op, logic [7:0] ch);
      int unsigned w;
      case (op)
        OP_CLEAR: begin
          clear_machine();
          mode = MODE_LOAD;
          return 1'b1;
        end
        OP_PCHAR: begin
          if (mode != MODE_LOAD) return 1'b0;
          store_char(ch);
          return 1'b1;
        end
        OP_LEND: begin
          if (mode != MODE_LOAD) return 1'b0;
          load_pos = 0;
          return 1'b1;
        end
        OP_STEP: begin
          if (mode == MODE_LOAD) begin
            ic   = 0;
            mode = MODE_RUN;
          end
          if (mode != MODE_RUN) return 1'b0;
          run_instruction();
          return 1'b1;
        end
        OP_DCHAR: begin
          if (mode != MODE_WAIT || data_pos >= DATA_CHARS) return 1'b0;
          w = data_addr + data_pos / 4;
          if (w < MEM_WORDS) mem[w][8*(3 - data_pos % 4) +: 8] = ch;
          data_pos++;
          return 1'b1;
        end
        OP_DEND: begin
          if (mode != MODE_WAIT) return 1'b0;
          while (data_pos < DATA_CHARS) begin
            w = data_addr + data_pos / 4;
            if (w < MEM_WORDS) mem[w][8*(3 - data_pos % 4) +: 8] = CH_SPACE;
            data_pos++;
          end
          mode = MODE_RUN;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    task report(input string what, input logic [31:0] want, input logic [31:0] got);
      if (mismatches < 200) $display("MISMATCH %s: expected %h, got %h", what, want, got);
      mismatches++;
    endtask

    task check_result(input logic [KIND_W-1:0] kind, input logic [31:0] word,
                      input logic last);
      vm_result_t want;
      if (due_results.size() == 0) begin
        report("result with none expected, kind/word", {30'h0, kind}, word);
        return;
      end
      want = due_results.pop_front();
      if (kind !== want.kind) report("out_kind", {30'h0, want.kind}, {30'h0, kind});
      if (word !== want.word) report("out_word", want.word, word);
      if (last !== want.last) report("last", {31'h0, want.last}, {31'h0, last});
    endtask
  endclass

endpackage

@@ tb/four_char_word_vm_executor_test.sv @@
// Top-level testbench of the four-character word machine executor: drives jobs, programs,
// steps and data lines, and checks every result. Depends on vmx_pkg, the RTL and the tracker.
`timescale 1ns / 1ps
module four_char_word_vm_executor_test;
  import vmx_pkg::*;
  import vm_job_tracker_pkg::*;

  // The two op codes that the machine has no use for.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned TOTAL_ITEMS = 260;

  logic clk;
  logic rst_n;

  vmx_in_if  in_chan ();
  vmx_out_if out_chan ();

  four_char_word_vm_executor u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  vm_job_tracker tracker = new();

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int unsigned send_gap_pct   = 31;
  int unsigned recv_stall_pct = 87;
  // Items taken by the block so far, whether the machine acted on them or not.
  int unsigned sent_items     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("four_char_word_vm_executor_test NOT OK");
    $finish;
  end

  // Result side. Handshake signals are read at the edge before any update at that edge
  // takes effect, so the item seen here is exactly the one the block hands over.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready)
        tracker.check_result(out_chan.out_kind, out_chan.out_word, out_chan.last);
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid is only lowered when a
  // gap is inserted, so back-to-back items never see valid dropped and raised in one step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] ch);
    if ($urandom_range(99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_chan.valid <= 1'b1;
    in_chan.op    <= op;
    in_chan.ch    <= ch;
    do @(posedge clk); while (!in_chan.ready);
    void'(tracker.note_input(op, ch));
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_PCHAR, s[i]);
  endtask

  // Sends a whole instruction word as four program characters, top byte first.
  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_item(OP_PCHAR, w[8*i +: 8]);
  endtask

  function automatic logic [15:0] digits(input int unsigned v);
    return {8'(CH_ZERO + v / 10), 8'(CH_ZERO + v % 10)};
  endfunction

  // Operand characters: mostly a valid address in [lo, hi], sometimes characters just
  // outside the digit range, sometimes anything at all.
  function automatic logic [15:0] pick_operand(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(11))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? {CH_ZERO - 8'd1, CH_NINE} : {CH_NINE, CH_NINE + 8'd1};
      default: return digits($urandom_range(hi, lo));
    endcase
  endfunction

  // Two short jobs that touch the field extremes and most of the special cases: ignored
  // items while idle, a spare op code, a halt that pads a part-filled word, a data line
  // with extreme bytes, a print of the topmost block, a line end mid-word and a bad operand.
  task automatic run_directed();
    send_item(OP_STEP, 8'h00);
    send_item(OP_SPARE_HI, 8'hFF);
    send_item(OP_SPARE_LO, 8'h00);
    send_item(OP_CLEAR, 8'h00);
    send_text("GD90PD90XH");
    send_item(OP_STEP, 8'hFF);
    send_item(OP_STEP, 8'h00);
    send_item(OP_DCHAR, 8'h00);
    send_item(OP_DCHAR, 8'hFF);
    send_item(OP_DEND, 8'h00);
    send_item(OP_STEP, 8'h00);
    send_item(OP_STEP, 8'h00);
    send_item(OP_STEP, 8'h00);
    send_item(OP_CLEAR, 8'hFF);
    send_text("PD");
    send_item(OP_LEND, 8'hA5);
    send_text("CR9A");
    send_item(OP_STEP, 8'h00);
    send_item(OP_PCHAR, "Z");
  endtask

  // Longer runs at the edges of memory: the counter walking off the end after a taken
  // branch, and a program that overflows memory while a halt pads the very last word.
  task automatic run_boundary_jobs();
    send_item(OP_CLEAR, 8'h00);
    send_text("CR50BT98");
    repeat (5) send_item(OP_STEP, 8'h00);
    send_item(OP_CLEAR, 8'hFF);
    repeat (MEM_WORDS - 1) send_item(OP_PCHAR, CH_H);
    send_text("aH");
    send_item(OP_PCHAR, "b");
    send_item(OP_STEP, 8'h00);
  endtask

  // One job with a random program, run until it stops or a step budget runs out. Data
  // lines are supplied whenever the machine asks for one.
  task automatic run_random_job();
    int unsigned n_words;
    int unsigned n_chars;
    int unsigned steps;
    logic [31:0] w;
    send_item(OP_CLEAR, 8'($urandom));
    n_words = $urandom_range(8, 1);
    for (int i = 0; i < n_words; i++) begin
      case ($urandom_range(9))
        0: w = {CH_G, CH_D, $urandom_range(3) == 0 ? pick_operand(0, 99)
                                                   : pick_operand(10, 90)};
        1: w = {CH_P, CH_D, $urandom_range(3) == 0 ? pick_operand(0, 99)
                                                   : pick_operand(10, 90)};
        2: w = {CH_L, CH_R, pick_operand(10, 30)};
        3: w = {CH_S, CH_R, pick_operand(10, 99)};
        4: w = {CH_C, CH_R, pick_operand(10, 30)};
        5: w = {CH_B, CH_T, pick_operand(0, n_words)};
        6: w = H_WORD;
        7: w = $urandom;
        8: w = SPACES;
        default: w = {CH_C, CH_R, pick_operand(0, 99)};
      endcase
      if (w == H_WORD) begin
        send_item(OP_PCHAR, CH_H);
      end else if (w == SPACES) begin
        // A short word closed by a halt, which pads it with spaces first.
        n_chars = $urandom_range(3, 1);
        repeat (n_chars) send_item(OP_PCHAR, 8'($urandom_range(8'h5A, 8'h41)));
        send_item(OP_PCHAR, CH_H);
      end else begin
        // Now and then a false start: a few characters, a line end, then the word again.
        if ($urandom_range(9) == 0) begin
          n_chars = $urandom_range(3, 1);
          for (int k = 0; k < n_chars; k++) send_item(OP_PCHAR, w[8*(3-k) +: 8]);
          send_item(OP_LEND, 8'($urandom));
        end
        send_word(w);
      end
    end
    steps = 0;
    while (tracker.mode != MODE_IDLE && steps < 40) begin
      if (tracker.mode == MODE_WAIT) begin
        n_chars = ($urandom_range(7) == 0) ? $urandom_range(44, 38) : $urandom_range(12);
        repeat (n_chars)
          send_item(OP_DCHAR, $urandom_range(1) ? 8'($urandom)
                                                : 8'($urandom_range(8'h5A, 8'h20)));
        if ($urandom_range(5) == 0) send_item(OP_STEP, 8'($urandom));
        send_item(OP_DEND, 8'($urandom));
      end else begin
        send_item(OP_STEP, 8'($urandom));
        steps++;
      end
    end
    // Stray items of any kind between jobs; most are ignored.
    if ($urandom_range(2) == 0) send_item(OP_W'($urandom), 8'($urandom));
  endtask

  initial begin
    int unsigned waited;
    int unsigned random_start;
    int unsigned random_span;
    in_chan.valid <= 1'b0;
    in_chan.op    <= OP_CLEAR;
    in_chan.ch    <= 8'h00;
    rst_n         <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_boundary_jobs();

    // Random part in three stretches: a mostly stalled receiver, then a mostly idle sender,
    // and finally both sides at full rate. It fills the run up to its item count.
    random_start = sent_items;
    random_span  = (TOTAL_ITEMS > random_start) ? TOTAL_ITEMS - random_start : 0;
    while (sent_items < TOTAL_ITEMS) begin
      if (sent_items - random_start >= 2 * random_span / 3) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end else if (sent_items - random_start >= random_span / 3) begin
        send_gap_pct   = 87;
        recv_stall_pct = 31;
      end
      run_random_job();
    end
    in_chan.valid <= 1'b0;

    // Let the block deliver what it still owes, then watch a little longer for strays.
    waited = 0;
    while (tracker.due_results.size() != 0 && waited < 100_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (tracker.due_results.size() != 0)
      tracker.report("results never delivered, count", tracker.due_results.size(), 32'h0);

    if (tracker.mismatches == 0) begin
      $display("four_char_word_vm_executor_test OK");
    end else begin
      $display("four_char_word_vm_executor_test NOT OK");
    end
    $finish;
  end

endmodule
